>>> src/qoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qoa_pkg;

	localparam int DATA_W = 16;
	localparam int HALF_W = 18;
	localparam int CW = 20;
	localparam int PROD_W = 2 * CW;
	localparam int SUM_W = 38;
	localparam int SQ_STEPS = SUM_W / 2;
	localparam int ROOT_W = 20;
	localparam int NUM_W = 36;
	localparam int REM_W = 22;
	localparam int ACC_W = 36;
	localparam int MPROD_W = 2 * DATA_W;
	localparam int CORDIC_STEPS = 16;
	localparam int QMUL_STEPS = 7;
	localparam int CNT_W = 6;
	localparam int PC_W = 6;
	localparam int LANES = 4;
	localparam int MAT_N = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [CW-1:0] PI_Q16 = 20'sd205887;
	localparam logic signed [CW-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [CW-1:0] GAIN_Q16 = 20'sd39797;
	localparam logic signed [DATA_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [ACC_W-1:0] ONE_Q28 = 36'sd268435456;
	localparam logic signed [ACC_W-1:0] ACC_HALF = 36'sd8192;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 36'sd32767;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -36'sd32768;
	localparam logic signed [PROD_W-1:0] PROD_HALF = 40'sd8192;

	typedef logic signed [DATA_W-1:0] q14_t;

	typedef struct packed {
		q14_t axis_x;
		q14_t axis_y;
		q14_t axis_z;
		logic signed [HALF_W-1:0] half;
		logic flip;
	} qoa_job_t;

	typedef struct packed {
		logic busy;
		logic mac_active;
	} qoa_back_st_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CORDIC,
		B_QMUL,
		B_SQRT,
		B_DSET,
		B_DIV,
		B_DSAT,
		B_COMP,
		B_CDRAIN,
		B_COMMIT,
		B_MAT,
		B_MDRAIN,
		B_OUT
	} back_state_t;

	localparam logic [2:0] SEL_NS = 3'd0;
	localparam logic [2:0] SEL_NX = 3'd1;
	localparam logic [2:0] SEL_NY = 3'd2;
	localparam logic [2:0] SEL_NZ = 3'd3;
	localparam logic [2:0] SEL_S = 3'd4;
	localparam logic [2:0] SEL_X = 3'd5;
	localparam logic [2:0] SEL_Y = 3'd6;
	localparam logic [2:0] SEL_Z = 3'd7;

	localparam logic [3:0] DST_TS = 4'd0;
	localparam logic [3:0] DST_TX = 4'd1;
	localparam logic [3:0] DST_TY = 4'd2;
	localparam logic [3:0] DST_TZ = 4'd3;
	localparam logic [3:0] DST_M00 = 4'd4;
	localparam logic [3:0] DST_M01 = 4'd5;
	localparam logic [3:0] DST_M02 = 4'd6;
	localparam logic [3:0] DST_M10 = 4'd7;
	localparam logic [3:0] DST_M11 = 4'd8;
	localparam logic [3:0] DST_M12 = 4'd9;
	localparam logic [3:0] DST_M20 = 4'd10;
	localparam logic [3:0] DST_M21 = 4'd11;
	localparam logic [3:0] DST_M22 = 4'd12;

	localparam logic [PC_W-1:0] PC_COMP_FIRST = 6'd0;
	localparam logic [PC_W-1:0] PC_COMP_LAST = 6'd15;
	localparam logic [PC_W-1:0] PC_MAT_FIRST = 6'd16;
	localparam logic [PC_W-1:0] PC_MAT_LAST = 6'd33;

	typedef struct packed {
		logic [2:0] a;
		logic [2:0] b;
		logic neg;
		logic dbl;
		logic first;
		logic one;
		logic last;
		logic [3:0] dst;
	} mac_op_t;

	function automatic mac_op_t mk(logic [2:0] a, logic [2:0] b, logic neg, logic dbl,
			logic first, logic one, logic last, logic [3:0] dst);
		mac_op_t o;
		o.a = a;
		o.b = b;
		o.neg = neg;
		o.dbl = dbl;
		o.first = first;
		o.one = one;
		o.last = last;
		o.dst = dst;
		return o;
	endfunction

	// The first sixteen steps compose the quaternions, the rest build the matrix.
	function automatic mac_op_t mac_op(logic [PC_W-1:0] pc);
		mac_op_t o;
		case (pc)
			6'd0: o = mk(SEL_NS, SEL_S, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_TS);
			6'd1: o = mk(SEL_NX, SEL_X, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_TS);
			6'd2: o = mk(SEL_NY, SEL_Y, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_TS);
			6'd3: o = mk(SEL_NZ, SEL_Z, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_TS);
			6'd4: o = mk(SEL_X, SEL_NS, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_TX);
			6'd5: o = mk(SEL_NX, SEL_S, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TX);
			6'd6: o = mk(SEL_NY, SEL_Z, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TX);
			6'd7: o = mk(SEL_NZ, SEL_Y, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_TX);
			6'd8: o = mk(SEL_Y, SEL_NS, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_TY);
			6'd9: o = mk(SEL_NY, SEL_S, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TY);
			6'd10: o = mk(SEL_NZ, SEL_X, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TY);
			6'd11: o = mk(SEL_NX, SEL_Z, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_TY);
			6'd12: o = mk(SEL_Z, SEL_NS, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_TZ);
			6'd13: o = mk(SEL_NZ, SEL_S, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TZ);
			6'd14: o = mk(SEL_NX, SEL_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TZ);
			6'd15: o = mk(SEL_NY, SEL_X, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_TZ);
			6'd16: o = mk(SEL_Y, SEL_Y, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, DST_M00);
			6'd17: o = mk(SEL_Z, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M00);
			6'd18: o = mk(SEL_X, SEL_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M01);
			6'd19: o = mk(SEL_S, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M01);
			6'd20: o = mk(SEL_X, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M02);
			6'd21: o = mk(SEL_S, SEL_Y, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_M02);
			6'd22: o = mk(SEL_X, SEL_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M10);
			6'd23: o = mk(SEL_S, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_M10);
			6'd24: o = mk(SEL_X, SEL_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, DST_M11);
			6'd25: o = mk(SEL_Z, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M11);
			6'd26: o = mk(SEL_Y, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M12);
			6'd27: o = mk(SEL_S, SEL_X, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M12);
			6'd28: o = mk(SEL_X, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M20);
			6'd29: o = mk(SEL_S, SEL_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M20);
			6'd30: o = mk(SEL_Y, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_M21);
			6'd31: o = mk(SEL_S, SEL_X, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_M21);
			6'd32: o = mk(SEL_X, SEL_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, DST_M22);
			6'd33: o = mk(SEL_Y, SEL_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, DST_M22);
			default: o = mk(SEL_S, SEL_S, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_TS);
		endcase
		return o;
	endfunction

	function automatic logic signed [CW-1:0] atan_q16(logic [3:0] i);
		logic signed [CW-1:0] v;
		case (i)
			4'd0: v = 20'sd51472;
			4'd1: v = 20'sd30386;
			4'd2: v = 20'sd16055;
			4'd3: v = 20'sd8150;
			4'd4: v = 20'sd4091;
			4'd5: v = 20'sd2047;
			4'd6: v = 20'sd1024;
			4'd7: v = 20'sd512;
			4'd8: v = 20'sd256;
			4'd9: v = 20'sd128;
			4'd10: v = 20'sd64;
			4'd11: v = 20'sd32;
			4'd12: v = 20'sd16;
			4'd13: v = 20'sd8;
			4'd14: v = 20'sd4;
			4'd15: v = 20'sd2;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

	function automatic q14_t sat_q28(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		q14_t o;
		r = (v + ACC_HALF) >>> 14;
		if (r > ACC_MAX) begin
			o = 16'sh7FFF;
		end else if (r < ACC_MIN) begin
			o = 16'sh8000;
		end else begin
			o = r[DATA_W-1:0];
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> src/qoa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qoa_in_if;
	import qoa_pkg::*;
	logic valid;
	logic ready;
	q14_t axis_x;
	q14_t axis_y;
	q14_t axis_z;
	q14_t angle;
	modport source (output valid, output axis_x, output axis_y, output axis_z, output angle,
		input ready);
	modport sink (input valid, input axis_x, input axis_y, input axis_z, input angle,
		output ready);
endinterface
`default_nettype wire

>>> src/qoa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qoa_out_if;
	import qoa_pkg::*;
	logic valid;
	logic ready;
	q14_t m00;
	q14_t m01;
	q14_t m02;
	q14_t m10;
	q14_t m11;
	q14_t m12;
	q14_t m20;
	q14_t m21;
	q14_t m22;
	logic degenerate;
	modport source (output valid, output m00, output m01, output m02, output m10, output m11,
		output m12, output m20, output m21, output m22, output degenerate, input ready);
	modport sink (input valid, input m00, input m01, input m02, input m10, input m11,
		input m12, input m20, input m21, input m22, input degenerate, output ready);
endinterface
`default_nettype wire

>>> src/qoa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module qoa_front (
	qoa_in_if.sink item,
	output qoa_pkg::qoa_job_t job,
	output logic job_valid,
	input logic job_ready
);
	import qoa_pkg::*;

	logic signed [CW-1:0] half_w;
	logic signed [CW-1:0] folded;
	logic flip;

	// The half angle is folded into [-pi/2, pi/2]; the flip negates sine and cosine later.
	always_comb begin
		half_w = {item.angle[DATA_W-1], item.angle, 3'b000};
		flip = 1'b0;
		folded = half_w;
		if (half_w > HALF_PI_Q16) begin
			folded = half_w - PI_Q16;
			flip = 1'b1;
		end else if (half_w < -HALF_PI_Q16) begin
			folded = half_w + PI_Q16;
			flip = 1'b1;
		end
	end

	assign job.axis_x = item.axis_x;
	assign job.axis_y = item.axis_y;
	assign job.axis_z = item.axis_z;
	assign job.half = folded[HALF_W-1:0];
	assign job.flip = flip;
	assign job_valid = item.valid;
	assign item.ready = job_ready;

endmodule
`default_nettype wire

>>> src/qoa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module qoa_queue #(
	parameter int DEPTH = qoa_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input qoa_pkg::qoa_job_t push_data,
	input logic push_valid,
	output logic push_ready,
	output qoa_pkg::qoa_job_t pop_data,
	output logic pop_valid,
	input logic pop_ready
);
	import qoa_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW_CNT = $clog2(DEPTH + 1);

	qoa_job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW_CNT-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CW_CNT'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/qoa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module qoa_back (
	input logic clk,
	input logic arst_n,
	input qoa_pkg::qoa_job_t job,
	input logic job_valid,
	output logic job_ready,
	qoa_out_if.source result,
	output qoa_pkg::qoa_back_st_t st
);
	import qoa_pkg::*;

	back_state_t state_q;
	back_state_t state_n;
	logic [CNT_W-1:0] cnt_q;
	qoa_job_t job_q;

	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cy_q;
	logic signed [CW-1:0] cz_q;
	logic signed [CW-1:0] cx_n;
	logic signed [CW-1:0] cy_n;
	logic signed [CW-1:0] cz_n;

	logic signed [CW-1:0] sn_q;
	logic signed [CW-1:0] qs_q;
	logic signed [CW-1:0] qx_q;
	logic signed [CW-1:0] qy_q;
	logic signed [CW-1:0] qz_q;
	logic signed [CW-1:0] ma;
	logic signed [CW-1:0] mb;
	logic signed [PROD_W-1:0] mprod;
	logic signed [PROD_W-1:0] mround;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W-1:0] trial;
	logic [ROOT_W-1:0] mag;
	logic degen_q;

	logic signed [CW-1:0] qv [LANES];
	logic [NUM_W-1:0] num_q [LANES];
	logic [REM_W-1:0] rem_q [LANES];
	logic neg_q [LANES];
	logic [REM_W-1:0] den_q;

	q14_t nq_q [LANES];
	q14_t st_q [LANES];
	q14_t tmp_q [LANES];
	q14_t mat_q [MAT_N];

	logic [PC_W-1:0] pc_q;
	logic issue;
	mac_op_t op;
	mac_op_t op_s1;
	logic vld_s1;
	logic signed [MPROD_W-1:0] prod_s1;
	q14_t opa;
	q14_t opb;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_n;
	logic [3:0] mat_idx;
	logic out_valid_q;
	logic out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		job_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_n = B_CORDIC;
				end
			end
			B_CORDIC: begin
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_n = B_QMUL;
				end
			end
			B_QMUL: begin
				if (cnt_q == CNT_W'(QMUL_STEPS - 1)) begin
					state_n = B_SQRT;
				end
			end
			B_SQRT: begin
				if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
					state_n = B_DSET;
				end
			end
			B_DSET: begin
				state_n = (mag == '0) ? B_MAT : B_DIV;
			end
			B_DIV: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_n = B_DSAT;
				end
			end
			B_DSAT: state_n = B_COMP;
			B_COMP: begin
				if (pc_q == PC_COMP_LAST) begin
					state_n = B_CDRAIN;
				end
			end
			B_CDRAIN: state_n = B_COMMIT;
			B_COMMIT: state_n = B_MAT;
			B_MAT: begin
				if (pc_q == PC_MAT_LAST) begin
					state_n = B_MDRAIN;
				end
			end
			B_MDRAIN: state_n = B_OUT;
			B_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_n = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_n != state_q) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// CORDIC rotation step.
	always_comb begin
		if (cz_q >= 0) begin
			cx_n = cx_q - (cy_q >>> cnt_q[3:0]);
			cy_n = cy_q + (cx_q >>> cnt_q[3:0]);
			cz_n = cz_q - atan_q16(cnt_q[3:0]);
		end else begin
			cx_n = cx_q + (cy_q >>> cnt_q[3:0]);
			cy_n = cy_q - (cx_q >>> cnt_q[3:0]);
			cz_n = cz_q + atan_q16(cnt_q[3:0]);
		end
	end

	// One multiplier scales the axis by the sine, then sums the squares.
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin
				ma = {{(CW - DATA_W){job_q.axis_x[DATA_W-1]}}, job_q.axis_x};
				mb = sn_q;
			end
			3'd1: begin
				ma = {{(CW - DATA_W){job_q.axis_y[DATA_W-1]}}, job_q.axis_y};
				mb = sn_q;
			end
			3'd2: begin
				ma = {{(CW - DATA_W){job_q.axis_z[DATA_W-1]}}, job_q.axis_z};
				mb = sn_q;
			end
			3'd3: begin
				ma = qs_q;
				mb = qs_q;
			end
			3'd4: begin
				ma = qx_q;
				mb = qx_q;
			end
			3'd5: begin
				ma = qy_q;
				mb = qy_q;
			end
			3'd6: begin
				ma = qz_q;
				mb = qz_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		mprod = ma * mb;
		mround = (mprod + PROD_HALF) >>> 14;
	end

	assign trial = root_q + bit_q;
	assign mag = root_q[ROOT_W-1:0];
	assign qv[0] = qs_q;
	assign qv[1] = qx_q;
	assign qv[2] = qy_q;
	assign qv[3] = qz_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q <= job;
				cx_q <= GAIN_Q16;
				cy_q <= '0;
				cz_q <= {{(CW - HALF_W){job.half[HALF_W-1]}}, job.half};
			end
			B_CORDIC: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
				sn_q <= job_q.flip ? -cy_n : cy_n;
				qs_q <= job_q.flip ? -cx_n : cx_n;
				sum_q <= '0;
			end
			B_QMUL: begin
				case (cnt_q[2:0])
					3'd0: qx_q <= mround[CW-1:0];
					3'd1: qy_q <= mround[CW-1:0];
					3'd2: qz_q <= mround[CW-1:0];
					default: sum_q <= sum_q + mprod[SUM_W-1:0];
				endcase
				root_q <= '0;
				bit_q <= {2'b01, {(SUM_W - 2){1'b0}}};
			end
			B_SQRT: begin
				if (sum_q >= trial) begin
					sum_q <= sum_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_DSET: begin
				degen_q <= (mag == '0);
				den_q <= REM_W'({mag, 1'b0});
				for (int l = 0; l < LANES; l++) begin
					neg_q[l] <= qv[l][CW-1];
					rem_q[l] <= '0;
					num_q[l] <= NUM_W'({(qv[l][CW-1] ? -qv[l] : qv[l]), 15'b0}) + NUM_W'(mag);
				end
			end
			B_DIV: begin
				for (int l = 0; l < LANES; l++) begin
					if ({rem_q[l][REM_W-2:0], num_q[l][NUM_W-1]} >= den_q) begin
						rem_q[l] <= {rem_q[l][REM_W-2:0], num_q[l][NUM_W-1]} - den_q;
						num_q[l] <= {num_q[l][NUM_W-2:0], 1'b1};
					end else begin
						rem_q[l] <= {rem_q[l][REM_W-2:0], num_q[l][NUM_W-1]};
						num_q[l] <= {num_q[l][NUM_W-2:0], 1'b0};
					end
				end
			end
			B_DSAT: begin
				for (int l = 0; l < LANES; l++) begin
					if (!neg_q[l]) begin
						nq_q[l] <= (num_q[l] > NUM_W'(32767)) ? 16'sh7FFF : num_q[l][DATA_W-1:0];
					end else begin
						nq_q[l] <= (num_q[l] > NUM_W'(32768)) ? 16'sh8000 : -num_q[l][DATA_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Multiply-accumulate sequencer for the composition and the matrix.
	assign issue = (state_q == B_COMP) || (state_q == B_MAT);
	assign op = mac_op(pc_q);

	always_comb begin
		case (op.a)
			SEL_NS: opa = nq_q[0];
			SEL_NX: opa = nq_q[1];
			SEL_NY: opa = nq_q[2];
			SEL_NZ: opa = nq_q[3];
			SEL_S: opa = st_q[0];
			SEL_X: opa = st_q[1];
			SEL_Y: opa = st_q[2];
			SEL_Z: opa = st_q[3];
			default: opa = '0;
		endcase
		case (op.b)
			SEL_NS: opb = nq_q[0];
			SEL_NX: opb = nq_q[1];
			SEL_NY: opb = nq_q[2];
			SEL_NZ: opb = nq_q[3];
			SEL_S: opb = st_q[0];
			SEL_X: opb = st_q[1];
			SEL_Y: opb = st_q[2];
			SEL_Z: opb = st_q[3];
			default: opb = '0;
		endcase
	end

	always_comb begin
		addend = {{(ACC_W - MPROD_W){prod_s1[MPROD_W-1]}}, prod_s1};
		if (op_s1.dbl) begin
			addend = addend <<< 1;
		end
		if (op_s1.first) begin
			base = op_s1.one ? ONE_Q28 : '0;
		end else begin
			base = acc_q;
		end
		acc_n = op_s1.neg ? base - addend : base + addend;
		mat_idx = op_s1.dst - DST_M00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				pc_q <= pc_q + 1'b1;
			end else if (state_q == B_DSAT) begin
				pc_q <= PC_COMP_FIRST;
			end else if (state_q == B_DSET) begin
				pc_q <= PC_MAT_FIRST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1 <= op;
			prod_s1 <= opa * opb;
		end
		if (vld_s1) begin
			acc_q <= acc_n;
			if (op_s1.last) begin
				if (op_s1.dst < DST_M00) begin
					tmp_q[op_s1.dst[1:0]] <= sat_q28(acc_n);
				end else begin
					mat_q[mat_idx] <= sat_q28(acc_n);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q[0] <= ONE_Q14;
			st_q[1] <= '0;
			st_q[2] <= '0;
			st_q[3] <= '0;
		end else if (state_q == B_COMMIT) begin
			st_q <= tmp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.m00 <= mat_q[0];
			result.m01 <= mat_q[1];
			result.m02 <= mat_q[2];
			result.m10 <= mat_q[3];
			result.m11 <= mat_q[4];
			result.m12 <= mat_q[5];
			result.m20 <= mat_q[6];
			result.m21 <= mat_q[7];
			result.m22 <= mat_q[8];
			result.degenerate <= degen_q;
		end
	end

	assign result.valid = out_valid_q;
	assign st.busy = (state_q != B_IDLE);
	assign st.mac_active = issue || vld_s1 || (state_q == B_CDRAIN) || (state_q == B_MDRAIN);

endmodule
`default_nettype wire

>>> src/quaternion_orientation_accumulator_unit.sv
// Orientation accumulator with an axis-angle request channel and a matrix result channel.
// Both channels use valid/ready; a request is taken at a clock edge where both are high.
// Each request carries a rotation axis (Q2.14) and an angle in radians (Q3.12). The block
// rotates its stored orientation quaternion by it and returns the 3x3 rotation matrix of
// the new orientation in Q2.14, plus a degenerate flag when the rotation had zero length
// (the orientation is then kept as it was).
// The front folds the half angle and writes the request into a small queue, so requests
// are taken while the back is busy until the queue fills. The back works on one request
// at a time: 16 CORDIC steps, 7 multiplier steps, 19 square-root steps, 36 divider steps
// in four parallel lanes, 16 plus 18 multiply-accumulate steps and the control states
// IDLE, DSET, DSAT, CDRAIN, COMMIT, MDRAIN and OUT. When a request is degenerate, the
// division and composition are skipped. The back takes the next queued request in the
// cycle after loading a result, so it starts a new request only once the result of the
// last one is loaded.
// The result sits in an output register; while the receiver stalls it holds, the back
// finishes the next request and then waits for the register to free.
// After reset the orientation is the identity and the queue is empty.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_orientation_accumulator_unit #(
	parameter int QUEUE_DEPTH = qoa_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	qoa_in_if.sink item,
	qoa_out_if.source result
);
	import qoa_pkg::*;

	qoa_job_t job_f;
	logic f_valid;
	logic f_ready;
	qoa_job_t job_b;
	logic b_valid;
	logic b_ready;
	qoa_back_st_t back_st;

	qoa_front u_front (
		.item(item),
		.job(job_f),
		.job_valid(f_valid),
		.job_ready(f_ready)
	);

	qoa_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(job_f),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.pop_data(job_b),
		.pop_valid(b_valid),
		.pop_ready(b_ready)
	);

	qoa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_b),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.result(result),
		.st(back_st)
	);

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> b_valid)
		else $error("queue empty after a request was taken");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |=> back_st.busy)
		else $error("back end idle after taking a request");

	a_mac_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.mac_active |-> back_st.busy)
		else $error("multiply-accumulate active while idle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(back_st.busy))
		else $error("result raised without a request in progress");

endmodule
`default_nettype wire

>>> sim/qoa_checker.sv
`timescale 1ns / 1ps
module qoa_checker (
	input logic clk,
	input logic arst_n,
	qoa_in_if item,
	qoa_out_if result,
	output int fail_count,
	output int pending,
	output int n_results,
	output int n_degenerate
);
	import qoa_pkg::*;

	typedef struct {
		q14_t m[9];
		logic degenerate;
	} matrix_t;

	matrix_t matrix_q[$];
	longint orient_s;
	longint orient_x;
	longint orient_y;
	longint orient_z;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic longint round_q14(longint v);
		return sat16(floor_shift(v + 8192, 14));
	endfunction

	function automatic longint int_sqrt(longint n);
		longint root;
		longint b;
		root = 0;
		b = longint'(1) << 62;
		while (b > n) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic longint div_nearest(longint num, longint den);
		longint a;
		longint q;
		a = (num < 0) ? -num : num;
		q = (2 * a + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return tbl[i];
	endfunction

	function automatic matrix_t rotate_orientation(q14_t ax, q14_t ay, q14_t az, q14_t ang);
		longint half;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		longint qs;
		longint qx;
		longint qy;
		longint qz;
		longint mag;
		longint ns;
		longint nx;
		longint ny;
		longint nz;
		longint vs;
		longint vx;
		longint vy;
		longint vz;
		longint dp;
		longint s;
		longint x;
		longint y;
		longint z;
		longint one;
		logic flip;
		matrix_t r;
		half = longint'(ang) * 8;
		flip = 1'b0;
		if (half > 102944) begin
			half = half - 205887;
			flip = 1'b1;
		end else if (half < -102944) begin
			half = half + 205887;
			flip = 1'b1;
		end
		cx = 39797;
		cy = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (half >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				half = half - atan_entry(i);
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				half = half + atan_entry(i);
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		qs = cx;
		qx = floor_shift(longint'(ax) * cy + 8192, 14);
		qy = floor_shift(longint'(ay) * cy + 8192, 14);
		qz = floor_shift(longint'(az) * cy + 8192, 14);
		mag = int_sqrt(qs * qs + qx * qx + qy * qy + qz * qz);
		r.degenerate = (mag == 0);
		if (mag != 0) begin
			ns = sat16(div_nearest(qs * 16384, mag));
			nx = sat16(div_nearest(qx * 16384, mag));
			ny = sat16(div_nearest(qy * 16384, mag));
			nz = sat16(div_nearest(qz * 16384, mag));
			vs = orient_s;
			vx = orient_x;
			vy = orient_y;
			vz = orient_z;
			dp = nx * vx + ny * vy + nz * vz;
			orient_s = round_q14(ns * vs - dp);
			orient_x = round_q14(vx * ns + nx * vs + (ny * vz - nz * vy));
			orient_y = round_q14(vy * ns + ny * vs + (nz * vx - nx * vz));
			orient_z = round_q14(vz * ns + nz * vs + (nx * vy - ny * vx));
		end
		s = orient_s;
		x = orient_x;
		y = orient_y;
		z = orient_z;
		one = longint'(1) << 28;
		r.m[0] = q14_t'(round_q14(one - 2 * y * y - 2 * z * z));
		r.m[1] = q14_t'(round_q14(2 * x * y - 2 * s * z));
		r.m[2] = q14_t'(round_q14(2 * x * z + 2 * s * y));
		r.m[3] = q14_t'(round_q14(2 * x * y + 2 * s * z));
		r.m[4] = q14_t'(round_q14(one - 2 * x * x - 2 * z * z));
		r.m[5] = q14_t'(round_q14(2 * y * z - 2 * s * x));
		r.m[6] = q14_t'(round_q14(2 * x * z - 2 * s * y));
		r.m[7] = q14_t'(round_q14(2 * y * z + 2 * s * x));
		r.m[8] = q14_t'(round_q14(one - 2 * x * x - 2 * y * y));
		return r;
	endfunction

	assign pending = matrix_q.size();

	always @(posedge clk or negedge arst_n) begin
		matrix_t want;
		q14_t got[9];
		logic bad;
		if (!arst_n) begin
			orient_s = 16384;
			orient_x = 0;
			orient_y = 0;
			orient_z = 0;
			fail_count <= 0;
			n_results <= 0;
			n_degenerate <= 0;
			matrix_q.delete();
		end else begin
			if (item.valid && item.ready) begin
				matrix_q.push_back(rotate_orientation(item.axis_x, item.axis_y, item.axis_z,
					item.angle));
			end
			if (result.valid && result.ready) begin
				n_results <= n_results + 1;
				if (result.degenerate) begin
					n_degenerate <= n_degenerate + 1;
				end
				got = '{result.m00, result.m01, result.m02, result.m10, result.m11,
					result.m12, result.m20, result.m21, result.m22};
				if (matrix_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("ERROR: matrix result with no request outstanding");
					end
					fail_count <= fail_count + 1;
				end else begin
					want = matrix_q.pop_front();
					bad = (want.degenerate !== result.degenerate);
					for (int i = 0; i < 9; i++) begin
						if (want.m[i] !== got[i]) begin
							bad = 1'b1;
						end
					end
					if (bad) begin
						if (fail_count < 10) begin
							$display("ERROR: result %0d expected m=%p degen=%0d, got m=%p degen=%0d",
								n_results, want.m, want.degenerate, got, result.degenerate);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import qoa_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int fail_count;
	int pending;
	int n_results;
	int n_degenerate;
	int idle_cycles = 0;
	int n_sent = 0;

	qoa_in_if item ();
	qoa_out_if result ();

	quaternion_orientation_accumulator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result)
	);

	qoa_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.fail_count(fail_count),
		.pending(pending),
		.n_results(n_results),
		.n_degenerate(n_degenerate)
	);

	always #1 clk = ~clk;

	initial begin
		item.valid = 1'b0;
		item.axis_x = '0;
		item.axis_y = '0;
		item.axis_z = '0;
		item.angle = '0;
		result.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			result.ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_rotation(q14_t ax, q14_t ay, q14_t az, q14_t ang);
		while (!calm && $urandom_range(99) < 35) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.axis_x <= ax;
		item.axis_y <= ay;
		item.axis_z <= az;
		item.angle <= ang;
		@(posedge clk);
		while (!item.ready) begin
			@(posedge clk);
		end
		n_sent++;
	endtask

	function automatic q14_t rand_field();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return q14_t'($urandom_range(32767) - 16384) >>> 1;
			default: return q14_t'($urandom);
		endcase
	endfunction

	initial begin
		q14_t ang;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_rotation(16'sd16384, 16'sd0, 16'sd0, 16'sd6434);
		send_rotation(16'sd0, 16'sd16384, 16'sd0, -16'sd6434);
		send_rotation(16'sd0, 16'sd0, 16'sd16384, 16'sd12868);
		send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd3000);
		send_rotation(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0);
		send_rotation(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_rotation(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd12868);
		send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd12868);
		send_rotation(16'sd1, 16'sd0, 16'sd0, 16'sd12868);
		send_rotation(16'sd100, -16'sd200, 16'sd300, 16'sd4096);
		send_rotation(-16'sd16384, 16'sd0, 16'sd0, 16'sd12870);
		send_rotation(16'sd0, -16'sd16384, 16'sd0, -16'sd12870);
		send_rotation(16'sd0, 16'sd0, 16'sd16384, 16'sd12867);
		send_rotation(16'sd16384, 16'sd0, 16'sd16384, 16'sh8000);
		send_rotation(16'sd0, 16'sd16384, 16'sd0, 16'sh7FFF);
		send_rotation(-16'sd1, -16'sd1, -16'sd1, 16'sd1);
		send_rotation(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		for (int i = 0; i < 950; i++) begin
			calm = (i >= 300 && i < 400);
			ang = ($urandom_range(9) == 0) ? rand_field() :
				q14_t'(int'($urandom_range(25736)) - 12868);
			if ($urandom_range(19) == 0) begin
				send_rotation(16'sd0, 16'sd0, 16'sd0, ang);
			end else begin
				send_rotation(rand_field(), rand_field(), rand_field(), ang);
			end
		end
		calm = 1'b0;
		item.valid <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		$display("Sent %0d rotations; %0d matrices checked, %0d of them degenerate.",
			n_sent, n_results, n_degenerate);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
